// ----- sv/eee_wtr_pkg.sv -----
// Types and constants shared by the EEE wake-time resolver modules.
package eee_wtr_pkg;

  typedef enum logic [2:0] {
    TXP_IDLE    = 3'd0,
    TXP_INIT    = 3'd1,
    TXP_RUN     = 3'd2,
    TXP_LOCAL   = 3'd3,
    TXP_REMOTE  = 3'd4,
    TXP_UPDATE  = 3'd5,
    TXP_REALLOC = 3'd6,
    TXP_MIRROR  = 3'd7
  } tx_phase_e;

  typedef enum logic [2:0] {
    RXP_IDLE    = 3'd0,
    RXP_INIT    = 3'd1,
    RXP_RUN     = 3'd2,
    RXP_CHANGE  = 3'd3,
    RXP_REALLOC = 3'd4,
    RXP_UPDATE  = 3'd5,
    RXP_MIRROR  = 3'd6
  } rx_phase_e;

  typedef enum logic [2:0] {
    CFG_TX_WAKE_1G    = 3'd0,
    CFG_TX_WAKE_100M  = 3'd1,
    CFG_RX_WAKE_1G    = 3'd2,
    CFG_RX_WAKE_100M  = 3'd3,
    CFG_PHY_WAKE_1G   = 3'd4,
    CFG_PHY_WAKE_100M = 3'd5,
    CFG_IDLE_TX_VALUE = 3'd6,
    CFG_IDLE_RX_VALUE = 3'd7
  } cfg_idx_e;

  localparam int unsigned TW = 16;

  localparam logic [TW-1:0] WAKE_1G_RST   = 16'd17;
  localparam logic [TW-1:0] WAKE_100M_RST = 16'd30;
  localparam logic [TW-1:0] IDLE_RST      = 16'd17;

  typedef logic [TW-1:0] time_t;

  typedef struct packed {
    time_t tx_wake_1g;
    time_t tx_wake_100m;
    time_t rx_wake_1g;
    time_t rx_wake_100m;
    time_t phy_wake_1g;
    time_t phy_wake_100m;
    time_t idle_tx_value;
    time_t idle_rx_value;
  } cfg_t;

  typedef struct packed {
    logic  link_up;
    logic  eee_enable;
    logic  speed_is_1g;
    logic  set_enable;
    logic  set_enable_value;
    logic  local_changed;
    logic  remote_valid;
    time_t remote_tx_time;
    time_t remote_rx_time;
    time_t remote_echo_tx;
    time_t remote_echo_rx;
  } item_t;

  typedef struct packed {
    tx_phase_e tx_phase;
    rx_phase_e rx_phase;
    time_t     loc_tx_value;
    time_t     loc_tx_echo;
    time_t     rem_rx_value;
    time_t     rem_rx_echo;
    time_t     resolved_tx;
    time_t     temp_rx;
    time_t     new_tx;
    time_t     loc_rx_value;
    time_t     loc_rx_echo;
    time_t     rem_tx_value;
    time_t     rem_tx_echo;
    time_t     resolved_rx;
    time_t     temp_tx;
    time_t     new_rx;
  } state_t;

  typedef struct packed {
    logic       chip_update;
    logic       chip_eee_on;
    time_t      chip_tx_wake;
    time_t      adv_tx_value;
    time_t      adv_rx_value;
    time_t      adv_echo_tx;
    time_t      adv_echo_rx;
    logic [2:0] tx_phase;
    logic [2:0] rx_phase;
  } result_t;

  function automatic time_t max_t(input time_t a, input time_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- sv/eee_wtr_cfg.sv -----
// Configuration register file of the EEE wake-time resolver.
module eee_wtr_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  eee_wtr_pkg::cfg_idx_e cfg_idx_i,
  input  eee_wtr_pkg::time_t    cfg_wdata_i,
  output eee_wtr_pkg::cfg_t     cfg_o
);
  import eee_wtr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TX_WAKE_1G:    cfg_d.tx_wake_1g    = cfg_wdata_i;
        CFG_TX_WAKE_100M:  cfg_d.tx_wake_100m  = cfg_wdata_i;
        CFG_RX_WAKE_1G:    cfg_d.rx_wake_1g    = cfg_wdata_i;
        CFG_RX_WAKE_100M:  cfg_d.rx_wake_100m  = cfg_wdata_i;
        CFG_PHY_WAKE_1G:   cfg_d.phy_wake_1g   = cfg_wdata_i;
        CFG_PHY_WAKE_100M: cfg_d.phy_wake_100m = cfg_wdata_i;
        CFG_IDLE_TX_VALUE: cfg_d.idle_tx_value = cfg_wdata_i;
        CFG_IDLE_RX_VALUE: cfg_d.idle_rx_value = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tx_wake_1g    <= WAKE_1G_RST;
      cfg_q.tx_wake_100m  <= WAKE_100M_RST;
      cfg_q.rx_wake_1g    <= WAKE_1G_RST;
      cfg_q.rx_wake_100m  <= WAKE_100M_RST;
      cfg_q.phy_wake_1g   <= WAKE_1G_RST;
      cfg_q.phy_wake_100m <= WAKE_100M_RST;
      cfg_q.idle_tx_value <= IDLE_RST;
      cfg_q.idle_rx_value <= IDLE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/eee_wtr_step.sv -----
// One tick of the transmit and receive wake-time diagrams, purely combinational.
module eee_wtr_step (
  input  eee_wtr_pkg::cfg_t    cfg_i,
  input  eee_wtr_pkg::state_t  st_i,
  input  eee_wtr_pkg::item_t   item_i,
  output eee_wtr_pkg::state_t  st_o,
  output eee_wtr_pkg::result_t res_o
);
  import eee_wtr_pkg::*;

  always_comb begin
    state_t    s;
    tx_phase_e tp;
    rx_phase_e rp;
    time_t     phy;
    time_t     loc_t;
    time_t     loc_r;
    time_t     wake;
    logic      chip;
    logic      chip_on;
    logic      lsc;

    s       = st_i;
    phy     = item_i.speed_is_1g ? cfg_i.phy_wake_1g : cfg_i.phy_wake_100m;
    loc_t   = item_i.speed_is_1g ? cfg_i.tx_wake_1g  : cfg_i.tx_wake_100m;
    loc_r   = item_i.speed_is_1g ? cfg_i.rx_wake_1g  : cfg_i.rx_wake_100m;
    wake    = '0;
    chip    = 1'b0;
    chip_on = 1'b0;
    lsc     = 1'b0;

    // enable request comes before the diagram step
    if (item_i.set_enable) begin
      if (item_i.link_up && item_i.set_enable_value) begin
        s.tx_phase = TXP_INIT;
        s.rx_phase = RXP_INIT;
      end else begin
        s.tx_phase = TXP_IDLE;
        s.rx_phase = RXP_IDLE;
      end
    end

    tp = s.tx_phase;
    rp = s.rx_phase;

    if (!item_i.eee_enable || !item_i.link_up || tp == TXP_IDLE || rp == RXP_IDLE) begin
      s.loc_tx_value = cfg_i.idle_tx_value;
      s.resolved_tx  = cfg_i.idle_tx_value;
      s.loc_rx_value = cfg_i.idle_rx_value;
      s.resolved_rx  = cfg_i.idle_rx_value;
      chip           = 1'b1;
      wake           = cfg_i.idle_tx_value;
    end else begin
      // transmit diagram; some states fall into the next within the tick
      if (tp == TXP_INIT) begin
        s.loc_tx_value = phy;
        s.loc_tx_echo  = phy;
        s.rem_rx_value = phy;
        s.rem_rx_echo  = phy;
        s.resolved_tx  = phy;
        s.temp_rx      = phy;
      end
      if (tp == TXP_INIT || tp == TXP_RUN) begin
        s.rem_rx_value = phy;
        if (item_i.remote_valid) begin
          s.rem_rx_value = item_i.remote_rx_time;
          s.rem_tx_echo  = item_i.remote_echo_tx;
        end
        if (item_i.local_changed) begin
          s.tx_phase = TXP_LOCAL;
        end else if (s.rem_rx_value != s.temp_rx || s.loc_tx_value != s.rem_tx_echo) begin
          s.tx_phase = TXP_REMOTE;
        end
      end else if (tp == TXP_LOCAL) begin
        s.temp_rx = s.rem_rx_value;
        s.new_tx  = max_t(loc_t, s.rem_rx_value);
        if (s.loc_tx_value == s.rem_tx_echo || s.new_tx < s.loc_tx_value) begin
          s.tx_phase = TXP_UPDATE;
        end else begin
          s.tx_phase = TXP_MIRROR;
        end
      end else begin
        if (tp == TXP_REMOTE) begin
          s.temp_rx = s.rem_rx_value;
          s.new_tx  = max_t(loc_t, s.rem_rx_value);
          tp        = TXP_UPDATE;
        end
        if (tp == TXP_UPDATE) begin
          s.loc_tx_value = s.new_tx;
          if (s.new_tx >= s.resolved_tx || s.new_tx >= s.temp_rx || s.resolved_tx == '0) begin
            s.tx_phase = TXP_REALLOC;
          end else begin
            s.tx_phase = TXP_MIRROR;
          end
        end else begin
          if (tp == TXP_REALLOC) begin
            s.resolved_tx = s.new_tx;
            wake          = s.new_tx;
            chip          = 1'b1;
            tp            = TXP_MIRROR;
          end
          if (tp == TXP_MIRROR) begin
            s.loc_rx_echo = s.temp_rx;
            s.tx_phase    = TXP_RUN;
          end
        end
      end
      chip_on = chip;

      // receive diagram, sees what the transmit step has just written
      if (rp == RXP_INIT) begin
        s.loc_rx_value = phy;
        s.loc_rx_echo  = phy;
        s.rem_tx_value = phy;
        s.rem_tx_echo  = phy;
        s.resolved_rx  = phy;
        s.temp_tx      = phy;
        lsc            = 1'b1;
      end
      if (rp == RXP_INIT || rp == RXP_RUN) begin
        s.rem_tx_value = phy;
        if (item_i.remote_valid) begin
          s.rem_tx_value = item_i.remote_tx_time;
          s.rem_rx_echo  = item_i.remote_echo_rx;
        end
        s.rx_phase = (s.rem_tx_value != s.temp_tx || lsc) ? RXP_CHANGE : RXP_RUN;
      end else if (rp == RXP_CHANGE) begin
        s.new_rx  = max_t(loc_r, s.rem_tx_value);
        s.temp_tx = s.rem_tx_value;
        if (s.new_rx <= s.resolved_rx || s.new_rx <= s.temp_tx || s.resolved_rx == '0) begin
          s.rx_phase = RXP_REALLOC;
        end else begin
          s.rx_phase = RXP_UPDATE;
        end
      end else if (rp == RXP_REALLOC || rp == RXP_UPDATE || rp == RXP_MIRROR) begin
        if (rp == RXP_REALLOC) begin
          s.resolved_rx = s.new_rx;
        end
        if (rp != RXP_MIRROR) begin
          s.loc_rx_value = s.new_rx;
        end
        s.loc_tx_echo = s.temp_tx;
        s.rx_phase    = RXP_RUN;
      end else begin
        // unused code: restart
        s.rx_phase = RXP_INIT;
      end
    end

    st_o               = s;
    res_o.chip_update  = chip;
    res_o.chip_eee_on  = chip_on;
    res_o.chip_tx_wake = chip ? wake : '0;
    res_o.adv_tx_value = s.loc_tx_value;
    res_o.adv_rx_value = s.loc_rx_value;
    res_o.adv_echo_tx  = item_i.eee_enable ? s.loc_tx_echo : '0;
    res_o.adv_echo_rx  = s.loc_rx_echo;
    res_o.tx_phase     = s.tx_phase;
    res_o.rx_phase     = s.rx_phase;
  end

endmodule

// ----- sv/eee_wake_time_resolver_core.sv -----
// An accepted item is held in the input register, then stepped into the result register.
// Throughput: one item per cycle; the diagram state and the result register update together.
// A stalled result holds the input register, which then stalls the input side; no item is lost.
// Reset: both phases idle, wake values at their idle defaults, config registers at defaults,
// no item held on either side; the item and result registers are not reset.
module eee_wake_time_resolver_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  eee_wtr_pkg::cfg_idx_e cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  link_up_i,
  input  logic                  eee_enable_i,
  input  logic                  speed_is_1g_i,
  input  logic                  set_enable_i,
  input  logic                  set_enable_value_i,
  input  logic                  local_changed_i,
  input  logic                  remote_valid_i,
  input  logic [15:0]           remote_tx_time_i,
  input  logic [15:0]           remote_rx_time_i,
  input  logic [15:0]           remote_echo_tx_i,
  input  logic [15:0]           remote_echo_rx_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  chip_update_o,
  output logic                  chip_eee_on_o,
  output logic [15:0]           chip_tx_wake_o,
  output logic [15:0]           adv_tx_value_o,
  output logic [15:0]           adv_rx_value_o,
  output logic [15:0]           adv_echo_tx_o,
  output logic [15:0]           adv_echo_rx_o,
  output logic [2:0]            tx_phase_o,
  output logic [2:0]            rx_phase_o
);
  import eee_wtr_pkg::*;

  cfg_t    cfg;
  item_t   item_d, item_q;
  state_t  st_q, st_d;
  result_t res_d, res_q;
  logic    in_valid_q, in_valid_d;
  logic    out_valid_q, out_valid_d;
  logic    accept;
  logic    advance;

  eee_wtr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  eee_wtr_step u_step (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .item_i (item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  assign item_d = '{
    link_up:          link_up_i,
    eee_enable:       eee_enable_i,
    speed_is_1g:      speed_is_1g_i,
    set_enable:       set_enable_i,
    set_enable_value: set_enable_value_i,
    local_changed:    local_changed_i,
    remote_valid:     remote_valid_i,
    remote_tx_time:   remote_tx_time_i,
    remote_rx_time:   remote_rx_time_i,
    remote_echo_tx:   remote_echo_tx_i,
    remote_echo_rx:   remote_echo_rx_i
  };

  // advance the held item when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.tx_phase     <= TXP_IDLE;
      st_q.rx_phase     <= RXP_IDLE;
      st_q.loc_tx_value <= IDLE_RST;
      st_q.loc_tx_echo  <= '0;
      st_q.rem_rx_value <= '0;
      st_q.rem_rx_echo  <= '0;
      st_q.resolved_tx  <= IDLE_RST;
      st_q.temp_rx      <= '0;
      st_q.new_tx       <= '0;
      st_q.loc_rx_value <= IDLE_RST;
      st_q.loc_rx_echo  <= '0;
      st_q.rem_tx_value <= '0;
      st_q.rem_tx_echo  <= '0;
      st_q.resolved_rx  <= IDLE_RST;
      st_q.temp_tx      <= '0;
      st_q.new_rx       <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chip_update_o  = res_q.chip_update;
  assign chip_eee_on_o  = res_q.chip_eee_on;
  assign chip_tx_wake_o = res_q.chip_tx_wake;
  assign adv_tx_value_o = res_q.adv_tx_value;
  assign adv_rx_value_o = res_q.adv_rx_value;
  assign adv_echo_tx_o  = res_q.adv_echo_tx;
  assign adv_echo_rx_o  = res_q.adv_echo_rx;
  assign tx_phase_o     = res_q.tx_phase;
  assign rx_phase_o     = res_q.rx_phase;

endmodule
